FILE: rtl/hid_keyboard_report_to_key_matrix_assert.svh
// Assertion macros shared by the keyboard report decoder.
// Depends on nothing; included by the top level, which checks its own logic.
`ifndef HID_KEYBOARD_REPORT_TO_KEY_MATRIX_ASSERT_SVH
`define HID_KEYBOARD_REPORT_TO_KEY_MATRIX_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HKM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hkm assertion failed");

// Next-cycle implication, disabled during reset.
`define HKM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hkm assertion failed");

`endif

FILE: rtl/hkm_pkg.sv
// Shared types, constants and helper functions of the keyboard report decoder.
// Depends on nothing; imported by every module of the block except hkm_ram.
`timescale 1ns / 1ps

package hkm_pkg;

    localparam int KEY_SLOTS    = 6;
    localparam int REPORT_SLOTS = 6;
    localparam int MAP_ENTRIES  = 128;
    localparam int MAP_AW       = $clog2(MAP_ENTRIES);
    localparam int MAP_VALUE_W  = 7;
    localparam int MATRIX_SIZE  = 128;
    localparam int MATRIX_AW    = $clog2(MATRIX_SIZE);

    localparam logic [MATRIX_AW-1:0] KEY_LSHIFT = MATRIX_AW'(42);
    localparam logic [MATRIX_AW-1:0] KEY_RSHIFT = MATRIX_AW'(54);
    localparam logic [MATRIX_AW-1:0] KEY_ALT    = MATRIX_AW'(56);
    localparam logic [MATRIX_AW-1:0] KEY_CTRL   = MATRIX_AW'(29);

    typedef enum logic [1:0] {
        OP_REPORT    = 2'd0,
        OP_MAP_WRITE = 2'd1,
        OP_QUERY     = 2'd2
    } op_t;

    // What one lane found for its key slot once the map copy has answered.
    typedef struct packed {
        logic                 clr_en;
        logic [MATRIX_AW-1:0] clr_idx;
        logic                 set_en;
        logic [MATRIX_AW-1:0] set_idx;
    } lane_res_t;

    // A code takes part only if it is below both the map size and the matrix size.
    function automatic logic code_in_map(input logic [7:0] code);
        logic ok;
        ok = ({1'b0, code} < 9'(MAP_ENTRIES)) && ({1'b0, code} < 9'(MATRIX_SIZE));
        return ok;
    endfunction

endpackage

FILE: rtl/hid_keyboard_report_to_key_matrix.sv
// Top level of the keyboard report decoder: input stage, lanes, merge, output register.
// Depends on hkm_pkg, hkm_lane, hkm_merge and the assertion macro header.
`timescale 1ns / 1ps

// One item is accepted every cycle while results are taken. Each accepted item first
// has its code map lookups registered in the first stage, then goes through the
// matrix update and the output register. Every key slot has its own copy of the
// code map with two read ports, so the previous and the current code of all slots are
// looked up in the same cycle; a map write goes to all copies at once. The map and the
// key matrix are usable right after reset, with no clearing pass: per-entry valid bits
// make unwritten map entries read as unmapped.
module hid_keyboard_report_to_key_matrix (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [1:0] op,
    input  logic [7:0] modifier_bits,
    input  logic [7:0] key_code_0,
    input  logic [7:0] key_code_1,
    input  logic [7:0] key_code_2,
    input  logic [7:0] key_code_3,
    input  logic [7:0] key_code_4,
    input  logic [7:0] key_code_5,
    input  logic       report_complete,
    input  logic [6:0] map_index,
    input  logic [6:0] map_value,
    input  logic [7:0] query_code,
    output logic       result_valid,
    input  logic       result_ready,
    output logic       key_down,
    output logic       report_skipped
);
    import hkm_pkg::*;

    logic [7:0]             keys_in [REPORT_SLOTS];
    logic [7:0]             cur [KEY_SLOTS];
    logic [7:0]             prev_keys_reg [KEY_SLOTS];
    logic [7:0]             prev_mods_reg;
    logic [KEY_SLOTS-1:0]   held;
    logic                   same;
    logic                   skip;
    logic                   accept;
    logic                   is_report;
    logic                   map_wr_en;
    logic [MAP_AW-1:0]      map_wr_addr;
    logic [MAP_ENTRIES-1:0] map_valid_reg;
    lane_res_t              lanes [KEY_SLOTS];

    logic                   s1_valid_reg;
    logic                   s1_go;
    logic                   s1_report_reg;
    logic                   s1_query_reg;
    logic                   s1_skip_reg;
    logic [7:0]             s1_mods_reg;
    logic [7:0]             s1_query_code_reg;
    logic                   key_down_s1;

    logic                   result_valid_reg;
    logic                   key_down_reg;
    logic                   report_skipped_reg;

    assign keys_in[0] = key_code_0;
    assign keys_in[1] = key_code_1;
    assign keys_in[2] = key_code_2;
    assign keys_in[3] = key_code_3;
    assign keys_in[4] = key_code_4;
    assign keys_in[5] = key_code_5;

    // Slots beyond those the report carries read as empty.
    for (genvar g = 0; g < KEY_SLOTS; g++)
    begin : g_cur
        if (g < REPORT_SLOTS)
        begin : g_port
            assign cur[g] = keys_in[g];
        end
        else
        begin : g_empty
            assign cur[g] = 8'd0;
        end
    end

    assign s1_go      = s1_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || s1_go;
    assign accept     = item_valid && item_ready;
    assign is_report  = (op == OP_REPORT);

    always_comb
    begin
        same = (modifier_bits == prev_mods_reg);
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (cur[i] != prev_keys_reg[i])
            begin
                same = 1'b0;
            end
            held[i] = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++)
            begin
                if (cur[j] == prev_keys_reg[i])
                begin
                    held[i] = 1'b1;
                end
            end
        end
        skip = report_complete && same;
    end

    assign map_wr_addr = MAP_AW'(map_index);
    assign map_wr_en   = accept && (op == OP_MAP_WRITE)
                         && ({2'b00, map_index} < 9'(MAP_ENTRIES));

    // The stored previous report follows each accepted complete report at once; an
    // incomplete one clears it, so the next report can be compared in the next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_mods_reg <= '0;
            map_valid_reg <= '0;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                prev_keys_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept && is_report)
            begin
                prev_mods_reg <= report_complete ? modifier_bits : 8'd0;
                for (int i = 0; i < KEY_SLOTS; i++)
                begin
                    prev_keys_reg[i] <= report_complete ? cur[i] : 8'd0;
                end
            end
            if (map_wr_en)
            begin
                map_valid_reg[map_wr_addr] <= 1'b1;
            end
        end
    end

    for (genvar g = 0; g < KEY_SLOTS; g++)
    begin : g_lane
        hkm_lane u_lane (
            .clk       (clk),
            .wr_en     (map_wr_en),
            .wr_addr   (map_wr_addr),
            .wr_data   (map_value),
            .map_valid (map_valid_reg),
            .rd_en     (accept && is_report),
            .old_code  (prev_keys_reg[g]),
            .new_code  (cur[g]),
            .held      (held[g]),
            .res       (lanes[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_report_reg     <= is_report;
            s1_query_reg      <= (op == OP_QUERY);
            s1_skip_reg       <= skip;
            s1_mods_reg       <= modifier_bits;
            s1_query_code_reg <= query_code;
        end
    end

    hkm_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (s1_go && s1_report_reg && !s1_skip_reg),
        .mods       (s1_mods_reg),
        .lanes      (lanes),
        .query_en   (s1_query_reg),
        .query_code (s1_query_code_reg),
        .key_down   (key_down_s1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (!result_valid_reg || result_ready)
        begin
            result_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            key_down_reg       <= key_down_s1;
            report_skipped_reg <= s1_report_reg && s1_skip_reg;
        end
    end

    assign result_valid   = result_valid_reg;
    assign key_down       = key_down_reg;
    assign report_skipped = report_skipped_reg;

`include "hid_keyboard_report_to_key_matrix_assert.svh"

    `HKM_ASSERT_NOW(a_result_exclusive, clk, rst_n, result_valid_reg, !(key_down_reg && report_skipped_reg))
    `HKM_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_reg && !s1_go, s1_valid_reg)
    `HKM_ASSERT_NEXT(a_map_valid_set, clk, rst_n, map_wr_en, map_valid_reg[$past(map_wr_addr)])
    `HKM_ASSERT_NOW(a_stall_cause, clk, rst_n, !item_ready, s1_valid_reg && result_valid_reg && !result_ready)

endmodule

FILE: rtl/hkm_ram.sv
// Generic single-write, dual-read RAM with registered read data and read enable.
// Depends on nothing.
`timescale 1ns / 1ps

module hkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a_reg <= mem_reg[rd_addr_a];
            rd_data_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

FILE: rtl/hkm_lane.sv
// One key-slot lane: a private copy of the code map looked up at the previous
// and the current code of its slot. Depends on hkm_pkg and hkm_ram.
`timescale 1ns / 1ps

module hkm_lane (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [hkm_pkg::MAP_AW-1:0]        wr_addr,
    input  logic [hkm_pkg::MAP_VALUE_W-1:0]   wr_data,
    input  logic [hkm_pkg::MAP_ENTRIES-1:0]   map_valid,
    input  logic                              rd_en,
    input  logic [7:0]                        old_code,
    input  logic [7:0]                        new_code,
    input  logic                              held,
    output hkm_pkg::lane_res_t                res
);
    import hkm_pkg::*;

    logic [MAP_AW-1:0]      prev_addr;
    logic [MAP_AW-1:0]      cur_addr;
    logic                   prev_use;
    logic                   cur_use;
    logic                   prev_use_reg;
    logic                   cur_use_reg;
    logic [MAP_VALUE_W-1:0] prev_val;
    logic [MAP_VALUE_W-1:0] cur_val;

    assign prev_addr = old_code[MAP_AW-1:0];
    assign cur_addr  = new_code[MAP_AW-1:0];

    // A released key needs a clear only if it is absent from the new report.
    // Entries never written read as unmapped through the shared valid bits.
    assign prev_use = (old_code != 8'd0) && code_in_map(old_code)
                      && map_valid[prev_addr] && !held;
    assign cur_use  = (new_code != 8'd0) && code_in_map(new_code)
                      && map_valid[cur_addr];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            prev_use_reg <= prev_use;
            cur_use_reg  <= cur_use;
        end
    end

    hkm_ram #(
        .WIDTH (MAP_VALUE_W),
        .DEPTH (MAP_ENTRIES)
    ) u_map (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (prev_addr),
        .rd_addr_b (cur_addr),
        .rd_data_a (prev_val),
        .rd_data_b (cur_val)
    );

    always_comb
    begin
        res.clr_en  = prev_use_reg && (prev_val != '0);
        res.clr_idx = MATRIX_AW'(prev_val);
        res.set_en  = cur_use_reg && (cur_val != '0);
        res.set_idx = MATRIX_AW'(cur_val);
    end

endmodule

FILE: rtl/hkm_merge.sv
// Merging stage: folds the clears and sets of all lanes plus the modifier keys
// into the key matrix, and answers key queries. Depends on hkm_pkg.
`timescale 1ns / 1ps

module hkm_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                update,
    input  logic [7:0]                          mods,
    input  hkm_pkg::lane_res_t                  lanes [hkm_pkg::KEY_SLOTS],
    input  logic                                query_en,
    input  logic [7:0]                          query_code,
    output logic                                key_down
);
    import hkm_pkg::*;

    logic [MATRIX_SIZE-1:0] matrix_reg;
    logic [MATRIX_SIZE-1:0] matrix_next;
    logic [MATRIX_SIZE-1:0] clr_vec;
    logic [MATRIX_SIZE-1:0] set_vec;

    always_comb
    begin
        clr_vec = '0;
        set_vec = '0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (lanes[i].clr_en)
            begin
                clr_vec[lanes[i].clr_idx] = 1'b1;
            end
            if (lanes[i].set_en)
            begin
                set_vec[lanes[i].set_idx] = 1'b1;
            end
        end
        // Clears go first, so a key held in another slot is set again.
        matrix_next = (matrix_reg & ~clr_vec) | set_vec;
        matrix_next[KEY_LSHIFT] = mods[1];
        matrix_next[KEY_RSHIFT] = mods[5];
        matrix_next[KEY_CTRL]   = mods[0] | mods[4];
        matrix_next[KEY_ALT]    = mods[2] | mods[6];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg <= '0;
        end
        else if (update)
        begin
            matrix_reg <= matrix_next;
        end
    end

    assign key_down = query_en && (query_code != 8'd0) && !query_code[7]
                      && matrix_reg[query_code[MATRIX_AW-1:0]];

endmodule

FILE: sim/hid_keyboard_report_to_key_matrix_tb.sv
// Testbench for the keyboard report decoder: directed and random items, checked in order.
// Depends on hkm_pkg and the hid_keyboard_report_to_key_matrix top level.
`timescale 1ns / 1ps

module hid_keyboard_report_to_key_matrix_tb;

    import hkm_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int WATCHDOG_LIMIT      = 1000;
    localparam int DRAIN_CYCLES        = 8;
    localparam int MAX_PRINTED         = 40;

    typedef struct packed {
        logic [1:0]                   op;
        logic [7:0]                   mods;
        logic [0:KEY_SLOTS-1][7:0]    codes;
        logic                         complete;
        logic [6:0]                   map_idx;
        logic [6:0]                   map_val;
        logic [7:0]                   query;
    } key_item_t;

    typedef struct {
        int   tag;
        logic key_down;
        logic report_skipped;
    } key_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    logic [1:0] op = '0;
    logic [7:0] modifier_bits = '0;
    logic [7:0] key_code_0 = '0;
    logic [7:0] key_code_1 = '0;
    logic [7:0] key_code_2 = '0;
    logic [7:0] key_code_3 = '0;
    logic [7:0] key_code_4 = '0;
    logic [7:0] key_code_5 = '0;
    logic       report_complete = 1'b0;
    logic [6:0] map_index = '0;
    logic [6:0] map_value = '0;
    logic [7:0] query_code = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic       key_down;
    logic       report_skipped;

    // Predicted copy of the block's state.
    logic                      key_state [MATRIX_SIZE] = '{default: 1'b0};
    logic [6:0]                code_table [MAP_ENTRIES] = '{default: 7'd0};
    logic [0:KEY_SLOTS-1][7:0] prior_codes = '0;
    logic [7:0]                prior_mods = '0;

    key_result_t pending_results [$];
    key_item_t   last_report = '0;
    int          items_sent = 0;
    int          fail_count = 0;
    int          quiet_cycles = 0;
    bit          src_idle = 1'b1;
    bit          sink_idle = 1'b1;

    hid_keyboard_report_to_key_matrix dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .op             (op),
        .modifier_bits  (modifier_bits),
        .key_code_0     (key_code_0),
        .key_code_1     (key_code_1),
        .key_code_2     (key_code_2),
        .key_code_3     (key_code_3),
        .key_code_4     (key_code_4),
        .key_code_5     (key_code_5),
        .report_complete(report_complete),
        .map_index      (map_index),
        .map_value      (map_value),
        .query_code     (query_code),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .key_down       (key_down),
        .report_skipped (report_skipped)
    );

    always #2 clk = ~clk;

    function automatic logic [6:0] map_code(input logic [7:0] code);
        if (code >= MAP_ENTRIES || code >= MATRIX_SIZE)
        begin
            return 7'd0;
        end
        return code_table[code[6:0]];
    endfunction

    // Applies one item to the predicted state and returns the result it should produce.
    function automatic key_result_t decode_item(input key_item_t it);
        key_result_t res;
        logic [6:0]  target;
        logic        held;
        res.tag = items_sent;
        res.key_down = 1'b0;
        res.report_skipped = 1'b0;
        case (it.op)
            OP_REPORT:
            begin
                if (it.complete && it.mods == prior_mods && it.codes == prior_codes)
                begin
                    res.report_skipped = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < KEY_SLOTS; i++)
                    begin
                        if (prior_codes[i] != 8'd0)
                        begin
                            held = 1'b0;
                            for (int j = 0; j < KEY_SLOTS; j++)
                            begin
                                if (it.codes[j] == prior_codes[i])
                                    held = 1'b1;
                            end
                            target = map_code(prior_codes[i]);
                            if (!held && target != 7'd0)
                                key_state[target] = 1'b0;
                        end
                    end
                    for (int i = 0; i < KEY_SLOTS; i++)
                    begin
                        target = map_code(it.codes[i]);
                        if (it.codes[i] != 8'd0 && target != 7'd0)
                            key_state[target] = 1'b1;
                    end
                    // Modifier bits win over any key code that maps onto them.
                    key_state[KEY_LSHIFT] = it.mods[1];
                    key_state[KEY_RSHIFT] = it.mods[5];
                    key_state[KEY_CTRL]   = it.mods[0] | it.mods[4];
                    key_state[KEY_ALT]    = it.mods[2] | it.mods[6];
                    if (it.complete)
                    begin
                        prior_codes = it.codes;
                        prior_mods  = it.mods;
                    end
                    else
                    begin
                        prior_codes = '0;
                        prior_mods  = '0;
                    end
                end
            end
            OP_MAP_WRITE:
            begin
                if (it.map_idx < MAP_ENTRIES)
                    code_table[it.map_idx] = it.map_val;
            end
            OP_QUERY:
            begin
                if (it.query != 8'd0 && it.query < MATRIX_SIZE)
                    res.key_down = key_state[it.query[6:0]];
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic key_item_t report_item(input logic [7:0] mods,
                                              input logic [0:KEY_SLOTS-1][7:0] codes,
                                              input logic complete);
        key_item_t it;
        it = '0;
        it.op = OP_REPORT;
        it.mods = mods;
        it.codes = codes;
        it.complete = complete;
        return it;
    endfunction

    function automatic key_item_t map_item(input logic [6:0] idx, input logic [6:0] val);
        key_item_t it;
        it = '0;
        it.op = OP_MAP_WRITE;
        it.map_idx = idx;
        it.map_val = val;
        return it;
    endfunction

    function automatic key_item_t query_item(input logic [7:0] code);
        key_item_t it;
        it = '0;
        it.op = OP_QUERY;
        it.query = code;
        return it;
    endfunction

    // Mostly well-formed traffic on a small set of hot codes; unused fields carry noise.
    function automatic key_item_t random_item();
        key_item_t it;
        int        pick;
        int        slot_pick;
        it.op = OP_UNUSED;
        it.mods = 8'($urandom);
        for (int s = 0; s < KEY_SLOTS; s++)
            it.codes[s] = 8'($urandom);
        it.complete = 1'($urandom);
        it.map_idx = 7'($urandom);
        it.map_val = 7'($urandom);
        it.query = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            it.op = OP_MAP_WRITE;
            if ($urandom_range(0, 3) != 0)
                it.map_idx = 7'($urandom_range(1, 31));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                it.map_val = 7'd0;
            else if (pick < 9)
                it.map_val = 7'($urandom_range(1, 48));
        end
        else if (pick < 55)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                // A repeat of the last report, which is skipped if that one was complete.
                it = last_report;
                it.complete = 1'b1;
            end
            else
            begin
                it.op = OP_REPORT;
                if ($urandom_range(0, 1) == 0)
                    it.mods = last_report.mods;
                for (int s = 0; s < KEY_SLOTS; s++)
                begin
                    slot_pick = $urandom_range(0, 9);
                    if (slot_pick < 3)
                        it.codes[s] = last_report.codes[s];
                    else if (slot_pick < 5)
                        it.codes[s] = 8'd0;
                    else if (slot_pick < 9)
                        it.codes[s] = 8'($urandom_range(1, 31));
                end
                it.complete = ($urandom_range(0, 9) != 0);
            end
            last_report = it;
        end
        else if (pick < 95)
        begin
            it.op = OP_QUERY;
            if ($urandom_range(0, 3) != 0)
                it.query = 8'($urandom_range(1, 60));
        end
        return it;
    endfunction

    task automatic report_mismatch(input int tag, input string what, input int got,
                                   input int want);
        if (fail_count < MAX_PRINTED)
            $display("mismatch at item %0d, %s: got %0d, want %0d", tag, what, got, want);
        fail_count++;
    endtask

    // Sends one item, with an optional idle burst first, and records its expected result.
    task automatic send_item(input key_item_t it);
        if (src_idle && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        item_valid      <= 1'b1;
        op              <= it.op;
        modifier_bits   <= it.mods;
        key_code_0      <= it.codes[0];
        key_code_1      <= it.codes[1];
        key_code_2      <= it.codes[2];
        key_code_3      <= it.codes[3];
        key_code_4      <= it.codes[4];
        key_code_5      <= it.codes[5];
        report_complete <= it.complete;
        map_index       <= it.map_idx;
        map_value       <= it.map_val;
        query_code      <= it.query;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        pending_results.push_back(decode_item(it));
        items_sent++;
    endtask

    task automatic test_code_map_writes();
        send_item(map_item(7'd0, 7'd127));
        send_item(map_item(7'd127, 7'd1));
        send_item(map_item(7'd4, 7'd4));
        send_item(map_item(7'd5, 7'd90));
        send_item(map_item(7'd85, KEY_LSHIFT));
    endtask

    task automatic test_report_updates();
        send_item(report_item(8'h00, {8'd4, 8'd5, 8'd127, 8'd0, 8'd255, 8'd128}, 1'b1));
        send_item(query_item(8'd4));
        send_item(query_item(8'd1));
        // An unchanged complete report is skipped.
        send_item(report_item(8'h00, {8'd4, 8'd5, 8'd127, 8'd0, 8'd255, 8'd128}, 1'b1));
        // Code 5 is held, the others are released; a key code lands on the shift bit.
        send_item(report_item(8'hFF, {8'd5, 8'd85, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1));
        send_item(query_item(8'd4));
        send_item(query_item(8'd42));
        send_item(query_item(8'd56));
        // An incomplete report is processed and then forgets the previous report.
        send_item(report_item(8'h00, {8'd85, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0));
        send_item(query_item(8'd42));
        send_item(report_item(8'h00, '0, 1'b1));
        send_item(map_item(7'd5, 7'd0));
        send_item(report_item(8'h11, {8'd5, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1));
        send_item(query_item(8'd29));
    endtask

    task automatic test_query_range();
        key_item_t it;
        send_item(query_item(8'd0));
        send_item(query_item(8'd128));
        send_item(query_item(8'd255));
        send_item(query_item(8'd127));
        it = '1;
        it.op = OP_UNUSED;
        send_item(it);
    endtask

    task automatic test_random_traffic();
        for (int k = 0; k < 32; k++)
            send_item(map_item(7'(k), 7'($urandom_range(1, 48))));
        for (int blk = 0; blk < 9; blk++)
        begin
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < 50; k++)
                send_item(random_item());
        end
    endtask

    task automatic test_quiet_tail();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        for (int k = 0; k < 40; k++)
            send_item(random_item());
    endtask

    // Receiver side: stalls in random bursts while idling is enabled.
    initial
    begin : result_sink
        forever
        begin
            @(posedge clk);
            if (rst_n && sink_idle && $urandom_range(0, 7) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        key_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch(-1, "result with no item waiting", 1, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (key_down !== want.key_down)
                    report_mismatch(want.tag, "key_down", key_down, want.key_down);
                if (report_skipped !== want.report_skipped)
                    report_mismatch(want.tag, "report_skipped", report_skipped,
                                    want.report_skipped);
            end
        end
    end

    // Ends the run when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL hid_keyboard_report_to_key_matrix");
            $finish;
        end
    end

    initial
    begin : run_tests
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_code_map_writes();
        test_report_updates();
        test_query_range();
        test_random_traffic();
        test_quiet_tail();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS hid_keyboard_report_to_key_matrix");
        else
            $display("FAIL hid_keyboard_report_to_key_matrix");
        $finish;
    end

endmodule
